/* hw/rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers for the grid path search block, empty under synthesis
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("%m: check failed");
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");
`else
`define ASSERT_ALWAYS(lbl, cond)
`define ASSERT_IMPLIES(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* hw/rtl/gaps_pkg.sv */
// ---------------------------------------------------------------------------
// gaps_pkg
// shared constants, micro-operation codes and controller interface types
// ---------------------------------------------------------------------------
package gaps_pkg;

  localparam int CELL_COUNT_DEF = 1024;
  localparam int FIELD_W        = 10;
  localparam int DIM_W          = 11;
  localparam int OUT_LEN_W      = 11;
  localparam int CFG_IDX_W      = 2;

  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_MISS  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

  localparam logic [DIM_W-1:0] WIDTH_RST  = 11'd32;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 11'd32;

  typedef enum logic [4:0] {
    U_IDLE, U_CLR_ALL, U_WRITE, U_RD_ADDR, U_RD_DATA, U_CHK, U_CHK2, U_CLR_VISIT,
    U_DIV_S, U_DIV_SW, U_DIV_G, U_DIV_GW, U_SEED, U_UP_ADDR, U_UP_CMP,
    U_TOP_ADDR, U_TOP_CHK, U_DN_LOAD, U_DN_ADDR, U_DN_LEFT, U_DN_RIGHT,
    U_NB_ADDR, U_NB_CHK, U_NB_NEXT, U_PATH_INIT, U_PATH_WR, U_PATH_RD,
    U_PATH_DONE, U_FINISH
  } uop_t;

  typedef struct packed {
    uop_t uop;
    logic take;
  } cmd_t;

  typedef struct packed {
    logic       req_valid;
    logic [1:0] op;
    logic       clr_last;
    logic       cfg_bad;
    logic       div_done;
    logic       up_root;
    logic       up_less;
    logic       top_hit;
    logic       dn_leaf;
    logic       dn_go;
    logic       nb_take;
    logic       dir_last;
    logic       heap_empty;
    logic       len_bad;
    logic       path_end;
    logic       out_free;
  } stat_t;

endpackage

/* hw/rtl/gaps_ram.sv */
// ---------------------------------------------------------------------------
// gaps_ram
// generic single write, single read memory with registered read data
// ---------------------------------------------------------------------------
module gaps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/gaps_div.sv */
// ---------------------------------------------------------------------------
// gaps_div
// restoring divider, one quotient bit per cycle, splits a cell index into x, y
// ---------------------------------------------------------------------------
module gaps_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [gaps_pkg::FIELD_W-1:0] dividend,
  input  logic [gaps_pkg::DIM_W-1:0]   divisor,
  output logic [gaps_pkg::FIELD_W-1:0] quo,
  output logic [gaps_pkg::DIM_W-1:0]   rem,
  output logic                        done
);

  localparam int NW = gaps_pkg::FIELD_W;
  localparam int DW = gaps_pkg::DIM_W;
  localparam int SW = $clog2(NW + 1);

  logic [SW-1:0] steps;
  logic [DW:0]   trial;

  assign trial = {rem, quo[NW-1]};
  assign done  = (steps == '0) && !start;

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
    end else if (start) begin
      steps <= SW'(NW);
    end else if (steps != '0) begin
      steps <= steps - SW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (steps != '0) begin
      if (trial >= {1'b0, divisor}) begin
        rem <= DW'(trial - {1'b0, divisor});
        quo <= {quo[NW-2:0], 1'b1};
      end else begin
        rem <= DW'(trial);
        quo <= {quo[NW-2:0], 1'b0};
      end
    end
  end

endmodule

/* hw/rtl/gaps_ctrl.sv */
// ---------------------------------------------------------------------------
// gaps_ctrl
// sequencer for grid writes, path reads and the heap based search
// ---------------------------------------------------------------------------
module gaps_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  gaps_pkg::stat_t  stat,
  output gaps_pkg::cmd_t   cmd,
  output logic             req_stall
);

  typedef enum logic [28:0] {
    S_RST_CLR = 29'd1 << 0,  S_IDLE   = 29'd1 << 1,  S_WRITE  = 29'd1 << 2,
    S_RD_ADDR = 29'd1 << 3,  S_RD_DAT = 29'd1 << 4,  S_CHK    = 29'd1 << 5,
    S_CHK2    = 29'd1 << 6,  S_VCLR   = 29'd1 << 7,  S_DIV_S  = 29'd1 << 8,
    S_DIV_SW  = 29'd1 << 9,  S_DIV_G  = 29'd1 << 10, S_DIV_GW = 29'd1 << 11,
    S_SEED    = 29'd1 << 12, S_UP     = 29'd1 << 13, S_UPC    = 29'd1 << 14,
    S_TOP     = 29'd1 << 15, S_TOPC   = 29'd1 << 16, S_DNL    = 29'd1 << 17,
    S_DN      = 29'd1 << 18, S_DNLFT  = 29'd1 << 19, S_DNRGT  = 29'd1 << 20,
    S_NB      = 29'd1 << 21, S_NBC    = 29'd1 << 22, S_NBN    = 29'd1 << 23,
    S_PINIT   = 29'd1 << 24, S_PW     = 29'd1 << 25, S_PR     = 29'd1 << 26,
    S_PDONE   = 29'd1 << 27, S_FIN    = 29'd1 << 28
  } state_t;

  state_t state, state_next;
  logic   seeding, seeding_next;
  logic   push_ret;

  assign req_stall = (state != S_IDLE);
  assign push_ret  = seeding;

  always_comb begin
    state_next   = state;
    seeding_next = seeding;
    cmd.take     = 1'b0;
    cmd.uop      = gaps_pkg::U_IDLE;
    case (state)
      S_RST_CLR: begin
        cmd.uop = gaps_pkg::U_CLR_ALL;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        cmd.uop = gaps_pkg::U_IDLE;
        if (stat.req_valid) begin
          cmd.take = 1'b1;
          case (stat.op)
            gaps_pkg::OP_WRITE:  state_next = S_WRITE;
            gaps_pkg::OP_SEARCH: state_next = S_CHK;
            gaps_pkg::OP_READ:   state_next = S_RD_ADDR;
            default:             state_next = S_FIN;
          endcase
        end
      end
      S_WRITE: begin
        cmd.uop    = gaps_pkg::U_WRITE;
        state_next = S_FIN;
      end
      S_RD_ADDR: begin
        cmd.uop    = gaps_pkg::U_RD_ADDR;
        state_next = S_RD_DAT;
      end
      S_RD_DAT: begin
        cmd.uop    = gaps_pkg::U_RD_DATA;
        state_next = S_FIN;
      end
      S_CHK: begin
        cmd.uop    = gaps_pkg::U_CHK;
        state_next = S_CHK2;
      end
      S_CHK2: begin
        cmd.uop    = gaps_pkg::U_CHK2;
        state_next = stat.cfg_bad ? S_FIN : S_VCLR;
      end
      S_VCLR: begin
        cmd.uop = gaps_pkg::U_CLR_VISIT;
        if (stat.clr_last) state_next = S_DIV_S;
      end
      S_DIV_S: begin
        cmd.uop    = gaps_pkg::U_DIV_S;
        state_next = S_DIV_SW;
      end
      S_DIV_SW: begin
        cmd.uop = gaps_pkg::U_DIV_SW;
        if (stat.div_done) state_next = S_DIV_G;
      end
      S_DIV_G: begin
        cmd.uop    = gaps_pkg::U_DIV_G;
        state_next = S_DIV_GW;
      end
      S_DIV_GW: begin
        cmd.uop = gaps_pkg::U_DIV_GW;
        if (stat.div_done) state_next = S_SEED;
      end
      S_SEED: begin
        cmd.uop      = gaps_pkg::U_SEED;
        seeding_next = 1'b1;
        state_next   = S_UP;
      end
      S_UP: begin
        cmd.uop = gaps_pkg::U_UP_ADDR;
        if (stat.up_root) state_next = push_ret ? S_TOP : S_NBN;
        else state_next = S_UPC;
      end
      S_UPC: begin
        cmd.uop = gaps_pkg::U_UP_CMP;
        if (stat.up_less) state_next = S_UP;
        else state_next = push_ret ? S_TOP : S_NBN;
      end
      S_TOP: begin
        cmd.uop      = gaps_pkg::U_TOP_ADDR;
        seeding_next = 1'b0;
        state_next   = S_TOPC;
      end
      S_TOPC: begin
        cmd.uop    = gaps_pkg::U_TOP_CHK;
        state_next = stat.top_hit ? S_PINIT : S_DNL;
      end
      S_DNL: begin
        cmd.uop    = gaps_pkg::U_DN_LOAD;
        state_next = S_DN;
      end
      S_DN: begin
        cmd.uop    = gaps_pkg::U_DN_ADDR;
        state_next = stat.dn_leaf ? S_NB : S_DNLFT;
      end
      S_DNLFT: begin
        cmd.uop    = gaps_pkg::U_DN_LEFT;
        state_next = S_DNRGT;
      end
      S_DNRGT: begin
        cmd.uop    = gaps_pkg::U_DN_RIGHT;
        state_next = stat.dn_go ? S_DN : S_NB;
      end
      S_NB: begin
        cmd.uop    = gaps_pkg::U_NB_ADDR;
        state_next = S_NBC;
      end
      S_NBC: begin
        cmd.uop    = gaps_pkg::U_NB_CHK;
        state_next = stat.nb_take ? S_UP : S_NBN;
      end
      S_NBN: begin
        cmd.uop = gaps_pkg::U_NB_NEXT;
        if (stat.dir_last) state_next = stat.heap_empty ? S_FIN : S_TOP;
        else state_next = S_NB;
      end
      S_PINIT: begin
        cmd.uop    = gaps_pkg::U_PATH_INIT;
        state_next = stat.len_bad ? S_FIN : S_PW;
      end
      S_PW: begin
        cmd.uop    = gaps_pkg::U_PATH_WR;
        state_next = stat.path_end ? S_PDONE : S_PR;
      end
      S_PR: begin
        cmd.uop    = gaps_pkg::U_PATH_RD;
        state_next = S_PW;
      end
      S_PDONE: begin
        cmd.uop    = gaps_pkg::U_PATH_DONE;
        state_next = S_FIN;
      end
      S_FIN: begin
        cmd.uop = gaps_pkg::U_FINISH;
        if (stat.out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_RST_CLR;
      seeding <= 1'b0;
    end else begin
      state   <= state_next;
      seeding <= seeding_next;
    end
  end

endmodule

/* hw/rtl/gaps_dp.sv */
// ---------------------------------------------------------------------------
// gaps_dp
// datapath: grid, visit, predecessor, heap and path memories with their logic
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module gaps_dp #(
  parameter int CELL_COUNT = gaps_pkg::CELL_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  gaps_pkg::cmd_t                 cmd,
  output gaps_pkg::stat_t                stat,
  input  logic                           cfg_valid,
  input  logic [gaps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gaps_pkg::DIM_W-1:0]     cfg_data,
  input  logic                           req_valid,
  input  logic [1:0]                     operation,
  input  logic [gaps_pkg::FIELD_W-1:0]   cell_index,
  input  logic                           blocked,
  input  logic [gaps_pkg::FIELD_W-1:0]   start_index,
  input  logic [gaps_pkg::FIELD_W-1:0]   goal_index,
  input  logic [gaps_pkg::FIELD_W-1:0]   path_position,
  input  logic                           rsp_stall,
  output logic                           rsp_valid,
  output logic [1:0]                     status,
  output logic                           found,
  output logic [gaps_pkg::OUT_LEN_W-1:0] path_length,
  output logic [gaps_pkg::FIELD_W-1:0]   path_cell
);

  localparam int PW = $clog2(CELL_COUNT);
  localparam int CW = PW + 1;
  localparam int XW = gaps_pkg::DIM_W;
  localparam int YW = PW;
  localparam int KW = ((PW > XW) ? PW : XW) + 2;
  localparam int FW = gaps_pkg::FIELD_W;
  localparam int LW = gaps_pkg::OUT_LEN_W;
  localparam int AW = 2 * gaps_pkg::DIM_W;

  typedef struct packed {
    logic [PW-1:0] pos;
    logic [XW-1:0] x;
    logic [YW-1:0] y;
    logic [CW-1:0] cost;
    logic [KW-1:0] key;
  } entry_t;

  localparam int EW = $bits(entry_t);

  function automatic logic [KW-1:0] est_of(input logic [XW-1:0] ax, input logic [XW-1:0] bx,
                                           input logic [YW-1:0] ay, input logic [YW-1:0] by);
    logic [XW-1:0] dx;
    logic [YW-1:0] dy;
    dx = (ax > bx) ? ax - bx : bx - ax;
    dy = (ay > by) ? ay - by : by - ay;
    return KW'(dx) + KW'(dy);
  endfunction

  // configuration and captured item
  logic [XW-1:0] grid_w, grid_h;
  logic [FW-1:0] cell_r, start_r, goal_r, posn_r;
  logic          blk_r;
  logic [AW-1:0] cells;

  // search state
  logic [XW-1:0] sx, gx;
  logic [YW-1:0] sy, gy;
  logic [CW-1:0] heap_cnt, length, stored_len;
  logic [PW-1:0] heap_i, heap_p, clr_cnt, wi, pw_pos;
  entry_t        ent, lrd, cur;
  logic [1:0]    dir;
  logic          nb_ok;
  logic [PW-1:0] nb_pos;
  logic [XW-1:0] nb_x;
  logic [YW-1:0] nb_y;
  logic [1:0]    res_status;
  logic [FW-1:0] res_cell;

  // memory ports
  logic          wall_we, wall_wd, wall_rd;
  logic [PW-1:0] wall_wa, nb_addr;
  logic          vis_we, vis_wd, vis_rd;
  logic [PW-1:0] vis_wa;
  logic          pred_we;
  logic [PW-1:0] pred_wa, pred_wd, pred_rd;
  logic          heap_we;
  logic [PW-1:0] heap_wa, heap_ra;
  entry_t        heap_wd, heap_rd;
  logic          path_we;
  logic [PW-1:0] path_rd;

  // divider
  logic          div_start;
  logic [FW-1:0] div_in, div_quo;
  logic [XW-1:0] div_rem;
  logic          div_done;

  // combinational helpers
  logic [CW-1:0] lchild;
  logic [CW:0]   rchild;
  logic [PW-1:0] parent;
  logic          r_ok, r_sel, out_free;
  entry_t        m_ent;
  logic [PW-1:0] m_idx;
  logic          n_ok;
  logic [PW-1:0] n_pos;
  logic [XW-1:0] n_x;
  logic [YW-1:0] n_y;

  assign lchild   = {heap_i, 1'b1};
  assign rchild   = {1'b0, heap_i, 1'b0} + (CW + 1)'(2);
  assign parent   = (heap_i - PW'(1)) >> 1;
  assign r_ok     = rchild < {1'b0, heap_cnt};
  assign r_sel    = r_ok && (heap_rd.key < lrd.key);
  assign m_ent    = r_sel ? heap_rd : lrd;
  assign m_idx    = r_sel ? PW'(rchild) : PW'(lchild);
  assign out_free = !rsp_valid || !rsp_stall;

  always_comb begin
    n_ok  = 1'b0;
    n_pos = cur.pos;
    n_x   = cur.x;
    n_y   = cur.y;
    case (dir)
      2'd0: begin
        n_ok  = (32'(cur.y) + 32'd1) < 32'(grid_h);
        n_pos = cur.pos + PW'(grid_w);
        n_y   = cur.y + YW'(1);
      end
      2'd1: begin
        n_ok  = cur.y != '0;
        n_pos = cur.pos - PW'(grid_w);
        n_y   = cur.y - YW'(1);
      end
      2'd2: begin
        n_ok  = cur.x != '0;
        n_pos = cur.pos - PW'(1);
        n_x   = cur.x - XW'(1);
      end
      default: begin
        n_ok  = (32'(cur.x) + 32'd1) < 32'(grid_w);
        n_pos = cur.pos + PW'(1);
        n_x   = cur.x + XW'(1);
      end
    endcase
  end

  // status to the controller
  always_comb begin
    stat.req_valid  = req_valid;
    stat.op         = operation;
    stat.clr_last   = clr_cnt == PW'(CELL_COUNT - 1);
    stat.cfg_bad    = (grid_w == '0) || (grid_h == '0) || (cells > AW'(CELL_COUNT)) ||
                      (AW'(start_r) >= cells) || (AW'(goal_r) >= cells);
    stat.div_done   = div_done;
    stat.up_root    = heap_i == '0;
    stat.up_less    = ent.key < heap_rd.key;
    stat.top_hit    = heap_rd.pos == PW'(goal_r);
    stat.dn_leaf    = lchild >= heap_cnt;
    stat.dn_go      = m_ent.key < ent.key;
    stat.nb_take    = nb_ok && !wall_rd && !vis_rd;
    stat.dir_last   = dir == 2'd3;
    stat.heap_empty = heap_cnt == '0;
    stat.len_bad    = length > CW'(CELL_COUNT);
    stat.path_end   = (pw_pos == PW'(start_r)) || (wi == '0);
    stat.out_free   = out_free;
  end

  // memory port selection
  always_comb begin
    wall_we = 1'b0;
    wall_wa = clr_cnt;
    wall_wd = 1'b0;
    vis_we  = 1'b0;
    vis_wa  = clr_cnt;
    vis_wd  = 1'b0;
    pred_we = 1'b0;
    pred_wa = nb_pos;
    pred_wd = cur.pos;
    heap_we = 1'b0;
    heap_wa = heap_i;
    heap_wd = ent;
    heap_ra = '0;
    path_we = 1'b0;
    div_start = 1'b0;
    div_in    = start_r;
    case (cmd.uop)
      gaps_pkg::U_CLR_ALL: begin
        wall_we = 1'b1;
        vis_we  = 1'b1;
      end
      gaps_pkg::U_WRITE: begin
        wall_we = 32'(cell_r) < CELL_COUNT;
        wall_wa = PW'(cell_r);
        wall_wd = blk_r;
      end
      gaps_pkg::U_CLR_VISIT: vis_we = 1'b1;
      gaps_pkg::U_DIV_S: div_start = 1'b1;
      gaps_pkg::U_DIV_G: begin
        div_start = 1'b1;
        div_in    = goal_r;
      end
      gaps_pkg::U_SEED: begin
        vis_we  = 1'b1;
        vis_wa  = PW'(start_r);
        vis_wd  = 1'b1;
        pred_we = 1'b1;
        pred_wa = PW'(start_r);
        pred_wd = PW'(start_r);
      end
      gaps_pkg::U_UP_ADDR: begin
        heap_we = heap_i == '0;
        heap_ra = parent;
      end
      gaps_pkg::U_UP_CMP: begin
        heap_we = 1'b1;
        heap_wd = (ent.key < heap_rd.key) ? heap_rd : ent;
      end
      gaps_pkg::U_TOP_CHK: heap_ra = PW'(heap_cnt - CW'(1));
      gaps_pkg::U_DN_ADDR: begin
        heap_we = lchild >= heap_cnt;
        heap_ra = PW'(lchild);
      end
      gaps_pkg::U_DN_LEFT: heap_ra = PW'(rchild);
      gaps_pkg::U_DN_RIGHT: begin
        heap_we = 1'b1;
        heap_wd = (m_ent.key < ent.key) ? m_ent : ent;
      end
      gaps_pkg::U_NB_CHK: begin
        if (nb_ok && !wall_rd && !vis_rd) begin
          vis_we  = 1'b1;
          vis_wa  = nb_pos;
          vis_wd  = 1'b1;
          pred_we = 1'b1;
        end
      end
      gaps_pkg::U_PATH_WR: path_we = 1'b1;
      default: begin
      end
    endcase
  end

  assign nb_addr = n_pos;

  gaps_ram #(.WIDTH(1), .DEPTH(CELL_COUNT)) u_wall (
    .clk(clk), .we(wall_we), .waddr(wall_wa), .wdata(wall_wd),
    .raddr(nb_addr), .rdata(wall_rd)
  );

  gaps_ram #(.WIDTH(1), .DEPTH(CELL_COUNT)) u_visit (
    .clk(clk), .we(vis_we), .waddr(vis_wa), .wdata(vis_wd),
    .raddr(nb_addr), .rdata(vis_rd)
  );

  gaps_ram #(.WIDTH(PW), .DEPTH(CELL_COUNT)) u_pred (
    .clk(clk), .we(pred_we), .waddr(pred_wa), .wdata(pred_wd),
    .raddr(pw_pos), .rdata(pred_rd)
  );

  gaps_ram #(.WIDTH(EW), .DEPTH(CELL_COUNT)) u_heap (
    .clk(clk), .we(heap_we), .waddr(heap_wa), .wdata(heap_wd),
    .raddr(heap_ra), .rdata(heap_rd)
  );

  gaps_ram #(.WIDTH(PW), .DEPTH(CELL_COUNT)) u_path (
    .clk(clk), .we(path_we), .waddr(wi), .wdata(pw_pos),
    .raddr(PW'(posn_r)), .rdata(path_rd)
  );

  gaps_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_in), .divisor(grid_w),
    .quo(div_quo), .rem(div_rem), .done(div_done)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_w     <= gaps_pkg::WIDTH_RST;
      grid_h     <= gaps_pkg::HEIGHT_RST;
      clr_cnt    <= '0;
      heap_cnt   <= '0;
      stored_len <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_index == gaps_pkg::REG_WIDTH) grid_w <= cfg_data;
      if (cfg_valid && cfg_index == gaps_pkg::REG_HEIGHT) grid_h <= cfg_data;
      if (cmd.uop == gaps_pkg::U_CLR_ALL || cmd.uop == gaps_pkg::U_CLR_VISIT) begin
        clr_cnt <= (clr_cnt == PW'(CELL_COUNT - 1)) ? '0 : clr_cnt + PW'(1);
      end
      case (cmd.uop)
        gaps_pkg::U_CHK: begin
          heap_cnt   <= '0;
          stored_len <= '0;
        end
        gaps_pkg::U_SEED, gaps_pkg::U_NB_CHK: begin
          if (cmd.uop == gaps_pkg::U_SEED || (nb_ok && !wall_rd && !vis_rd)) begin
            heap_cnt <= heap_cnt + CW'(1);
          end
        end
        gaps_pkg::U_TOP_CHK: begin
          if (heap_rd.pos != PW'(goal_r)) heap_cnt <= heap_cnt - CW'(1);
          else heap_cnt <= '0;
        end
        gaps_pkg::U_PATH_DONE: stored_len <= length;
        default: begin
        end
      endcase
      if (cmd.uop == gaps_pkg::U_FINISH && out_free) rsp_valid <= 1'b1;
      else if (!rsp_stall) rsp_valid <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (cmd.uop)
      gaps_pkg::U_IDLE: begin
        if (cmd.take) begin
          cell_r     <= cell_index;
          blk_r      <= blocked;
          start_r    <= start_index;
          goal_r     <= goal_index;
          posn_r     <= path_position;
          res_status <= gaps_pkg::ST_RANGE;
          res_cell   <= '0;
        end
      end
      gaps_pkg::U_WRITE: begin
        if (32'(cell_r) < CELL_COUNT) res_status <= gaps_pkg::ST_DONE;
      end
      gaps_pkg::U_RD_DATA: begin
        if ((CW'(posn_r) < stored_len) && (32'(posn_r) < CELL_COUNT)) begin
          res_status <= gaps_pkg::ST_DONE;
          res_cell   <= FW'(path_rd);
        end else begin
          res_status <= gaps_pkg::ST_MISS;
        end
      end
      gaps_pkg::U_CHK: cells <= AW'(grid_w) * AW'(grid_h);
      gaps_pkg::U_DIV_SW: begin
        sx <= div_rem;
        sy <= YW'(div_quo);
      end
      gaps_pkg::U_DIV_GW: begin
        gx <= div_rem;
        gy <= YW'(div_quo);
      end
      gaps_pkg::U_SEED: begin
        ent.pos  <= PW'(start_r);
        ent.x    <= sx;
        ent.y    <= sy;
        ent.cost <= '0;
        ent.key  <= est_of(sx, gx, sy, gy);
        heap_i   <= PW'(heap_cnt);
      end
      gaps_pkg::U_UP_ADDR: heap_p <= parent;
      gaps_pkg::U_UP_CMP: begin
        if (ent.key < heap_rd.key) heap_i <= heap_p;
      end
      gaps_pkg::U_TOP_CHK: begin
        cur    <= heap_rd;
        dir    <= '0;
        length <= heap_rd.cost + CW'(1);
      end
      gaps_pkg::U_DN_LOAD: begin
        ent    <= heap_rd;
        heap_i <= '0;
      end
      gaps_pkg::U_DN_LEFT: lrd <= heap_rd;
      gaps_pkg::U_DN_RIGHT: begin
        if (m_ent.key < ent.key) heap_i <= m_idx;
      end
      gaps_pkg::U_NB_ADDR: begin
        nb_ok  <= n_ok;
        nb_pos <= n_pos;
        nb_x   <= n_x;
        nb_y   <= n_y;
      end
      gaps_pkg::U_NB_CHK: begin
        ent.pos  <= nb_pos;
        ent.x    <= nb_x;
        ent.y    <= nb_y;
        ent.cost <= cur.cost + CW'(1);
        ent.key  <= KW'(cur.cost + CW'(1)) + est_of(nb_x, gx, nb_y, gy);
        heap_i   <= PW'(heap_cnt);
      end
      gaps_pkg::U_NB_NEXT: begin
        dir <= dir + 2'd1;
        if (dir == 2'd3 && heap_cnt == '0) res_status <= gaps_pkg::ST_MISS;
      end
      gaps_pkg::U_PATH_INIT: begin
        wi     <= PW'(length - CW'(1));
        pw_pos <= PW'(goal_r);
        if (length > CW'(CELL_COUNT)) res_status <= gaps_pkg::ST_MISS;
      end
      gaps_pkg::U_PATH_WR: begin
        if (wi != '0) wi <= wi - PW'(1);
      end
      gaps_pkg::U_PATH_RD: pw_pos <= pred_rd;
      gaps_pkg::U_PATH_DONE: res_status <= gaps_pkg::ST_DONE;
      gaps_pkg::U_FINISH: begin
        if (out_free) begin
          status      <= res_status;
          found       <= stored_len != '0;
          path_length <= LW'(stored_len);
          path_cell   <= res_cell;
        end
      end
      default: begin
      end
    endcase
  end

  `ASSERT_ALWAYS(a_heap_bound, heap_cnt <= CW'(CELL_COUNT))
  `ASSERT_IMPLIES(a_up_below_root, cmd.uop == gaps_pkg::U_UP_CMP, heap_i != '0)
  `ASSERT_IMPLIES(a_path_index, cmd.uop == gaps_pkg::U_PATH_WR, CW'(wi) < length)
  `ASSERT_NEXT(a_result_loaded, cmd.uop == gaps_pkg::U_FINISH && out_free, rsp_valid)

endmodule

/* hw/rtl/grid_astar_path_search.sv */
// ---------------------------------------------------------------------------
// grid_astar_path_search
// A* search over a 4-connected occupancy grid with a binary min-heap open set
// ---------------------------------------------------------------------------
// channel  direction  handshake             contents
// req      in         req_valid/req_stall   operation and its operands
// rsp      out        rsp_valid/rsp_stall   status, found, path_length, path_cell
// cfg      in         cfg_valid/cfg_ready   cfg_index, cfg_data (width, height)
//
// a grid write or path read is handled one item at a time
// a search clears the visit map, then splits start and goal into x and y,
// then per expanded cell makes 4 neighbour probes plus heap sifts up and
// down, all on the single heap memory
// after reset the grid and visit memories are cleared
// a result held by rsp_stall blocks the next item only at its own finish
// ---------------------------------------------------------------------------
module grid_astar_path_search #(
  parameter int CELL_COUNT = gaps_pkg::CELL_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  logic [1:0]                     operation,
  input  logic [gaps_pkg::FIELD_W-1:0]   cell_index,
  input  logic                           blocked,
  input  logic [gaps_pkg::FIELD_W-1:0]   start_index,
  input  logic [gaps_pkg::FIELD_W-1:0]   goal_index,
  input  logic [gaps_pkg::FIELD_W-1:0]   path_position,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output logic [1:0]                     status,
  output logic                           found,
  output logic [gaps_pkg::OUT_LEN_W-1:0] path_length,
  output logic [gaps_pkg::FIELD_W-1:0]   path_cell,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gaps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gaps_pkg::DIM_W-1:0]     cfg_data
);

  gaps_pkg::cmd_t  cmd;
  gaps_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  gaps_ctrl u_ctrl (
    .clk(clk), .rst(rst), .stat(stat), .cmd(cmd), .req_stall(req_stall)
  );

  gaps_dp #(.CELL_COUNT(CELL_COUNT)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req_valid(req_valid), .operation(operation), .cell_index(cell_index),
    .blocked(blocked), .start_index(start_index), .goal_index(goal_index),
    .path_position(path_position), .rsp_stall(rsp_stall), .rsp_valid(rsp_valid),
    .status(status), .found(found), .path_length(path_length), .path_cell(path_cell)
  );

endmodule
